>>> hdl/pest_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pest_pkg: shared definitions for the periodic event slot table
// Command codes, slot entry layout and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package pest_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_REG   = 2'd1;
    localparam logic [1:0] CMD_UNREG = 2'd2;

    // result kinds
    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    localparam int TICK_MS    = 10;
    localparam int TICK_ROUND = TICK_MS - 1;
    localparam int LEGACY_DIV = 5;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for any x below 2^32
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam int MS_W     = 24;
    localparam int MSR_W    = MS_W + 1;
    localparam int PERIOD_W = 21;
    localparam int TICK_W   = 32;
    localparam int LEGACY_W = 30;
    localparam int HID_W    = 8;

    typedef struct packed {
        logic [HID_W-1:0]    handler;
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   due;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage
`default_nettype wire

>>> hdl/pest_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pest_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/pest_div10.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pest_div10: divide by ten through a registered reciprocal multiply
// Quotient is valid in the cycle after the dividend is presented.
// ----------------------------------------------------------------------------
module pest_div10
    import pest_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic [MSR_W-1:0]    i_dividend,
    output logic      [PERIOD_W-1:0] o_quotient
);

    localparam int PROD_W = MSR_W + 32;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_dividend) * PROD_W'(DIV10_MUL);
    end

    assign o_quotient = r_prod[DIV10_SHIFT +: PERIOD_W];

endmodule
`default_nettype wire

>>> hdl/periodic_event_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_event_slot_table: tick driven table of periodic event slots
// Register/unregister handlers, fire due slots on each tick, legacy /5 count.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------------
//  command   | start / busy     | i_cmd, i_period_ms, i_handler_id
//  result    | o_valid (strobe) | o_result_kind, o_status, o_slot_index,
//            |                  | o_fired_handler, o_tick_value,
//            |                  | o_legacy_update, o_legacy_count, o_last
//
//  A command transaction that walks the table keeps busy high while it
//  issues one read per slot, waits out the RAM read latency of the last
//  slot, then passes through the completion state. A rejected register or
//  an unknown command skips the walk and keeps busy high only for the
//  completion state. Result transactions come out one per cycle at most,
//  each valid for exactly one cycle; the receiver cannot stall. Reset clears
//  the occupancy bits, so the RAM needs no clearing pass and the block takes
//  a command in the first cycle after reset.
// ----------------------------------------------------------------------------
module periodic_event_slot_table
    import pest_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_cmd,
    input  wire logic [MS_W-1:0]     i_period_ms,
    input  wire logic [HID_W-1:0]    i_handler_id,
    output logic                     o_valid,
    output logic                     o_result_kind,
    output logic                     o_status,
    output logic [2:0]               o_slot_index,
    output logic [HID_W-1:0]         o_fired_handler,
    output logic [TICK_W-1:0]        o_tick_value,
    output logic                     o_legacy_update,
    output logic [LEGACY_W-1:0]      o_legacy_count,
    output logic                     o_last
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_pv, n_pv;
    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [2:0]            r_phase, n_phase;
    logic [LEGACY_W-1:0]   r_legacy, n_legacy;
    logic                  r_valid, n_valid;

    // per-command working registers
    logic [AW-1:0]         r_pidx, n_pidx;
    logic [1:0]            r_cmd, n_cmd;
    logic [HID_W-1:0]      r_hid, n_hid;
    logic [MSR_W-1:0]      r_ms_rnd, n_ms_rnd;
    logic                  r_fail, n_fail;
    logic                  r_found, n_found;
    logic [2:0]            r_sel, n_sel;
    logic                  r_upd, n_upd;

    // result register
    logic                  r_kind, n_kind;
    logic                  r_stat, n_stat;
    logic [2:0]            r_oslot, n_oslot;
    logic [HID_W-1:0]      r_ohid, n_ohid;
    logic                  r_oupd, n_oupd;
    logic [LEGACY_W-1:0]   r_olcnt, n_olcnt;
    logic                  r_olast, n_olast;

    // slot RAM
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_wdata;
    logic [SLOT_W-1:0]     ram_rdata;
    t_slot                 rd_slot;
    t_slot                 wr_slot;
    logic [PERIOD_W-1:0]   period;
    logic                  accept;
    logic                  occ;

    pest_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pidx),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ceil(ms / 10) from r_ms_rnd (ms + 9, registered at accept) via the divider's product register, in time for slot 0
    pest_div10 u_div10 (
        .i_clk      (i_clk),
        .i_dividend (r_ms_rnd),
        .o_quotient (period)
    );

    assign accept    = start && (r_state == S_IDLE);
    assign rd_slot   = t_slot'(ram_rdata);
    assign occ       = r_used[r_pidx];
    assign ram_wdata = SLOT_W'(wr_slot);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pv     = 1'b0;
        n_used   = r_used;
        n_tick   = r_tick;
        n_phase  = r_phase;
        n_legacy = r_legacy;
        n_valid  = 1'b0;
        n_pidx   = r_pidx;
        n_cmd    = r_cmd;
        n_hid    = r_hid;
        n_ms_rnd = r_ms_rnd;
        n_fail   = r_fail;
        n_found  = r_found;
        n_sel    = r_sel;
        n_upd    = r_upd;
        n_kind   = r_kind;
        n_stat   = r_stat;
        n_oslot  = r_oslot;
        n_ohid   = r_ohid;
        n_oupd   = r_oupd;
        n_olcnt  = r_olcnt;
        n_olast  = r_olast;
        ram_we   = 1'b0;
        wr_slot  = rd_slot;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_hid    = i_handler_id;
                    n_ms_rnd = MSR_W'(i_period_ms) + MSR_W'(TICK_ROUND);
                    n_cnt    = '0;
                    n_found  = 1'b0;
                    n_sel    = '0;
                    n_upd    = 1'b0;
                    n_state  = S_SCAN;
                    case (i_cmd)
                        CMD_TICK: begin
                            n_fail = STAT_OK;
                            n_tick = r_tick + 1'b1;
                            // legacy report tracks count mod 5 and count / 5
                            if (n_tick == '0) begin
                                n_phase  = '0;
                                n_legacy = '0;
                                n_upd    = 1'b1;
                            end else if (r_phase == 3'(LEGACY_DIV - 1)) begin
                                n_phase  = '0;
                                n_legacy = r_legacy + 1'b1;
                                n_upd    = 1'b1;
                            end else begin
                                n_phase = r_phase + 1'b1;
                            end
                        end
                        CMD_REG: begin
                            n_fail = STAT_FAIL;
                            if (i_handler_id == '0 || i_period_ms == '0) begin
                                n_state = S_DONE;
                            end
                        end
                        CMD_UNREG: begin
                            n_fail = STAT_FAIL;
                        end
                        default: begin
                            n_fail  = STAT_FAIL;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the read for slot r_cnt, work on slot r_pidx
                if (r_cnt != CW'(SLOT_COUNT)) begin
                    n_pv   = 1'b1;
                    n_pidx = r_cnt[AW-1:0];
                    n_cnt  = r_cnt + 1'b1;
                end else begin
                    n_state = S_DONE;
                end

                if (r_pv) begin
                    case (r_cmd)
                        CMD_TICK: begin
                            if (occ && (r_tick >= rd_slot.due)) begin
                                ram_we      = 1'b1;
                                wr_slot.due = r_tick + TICK_W'(rd_slot.period);
                                n_valid     = 1'b1;
                                n_kind      = KIND_FIRE;
                                n_stat      = STAT_OK;
                                n_oslot     = 3'(r_pidx);
                                n_ohid      = rd_slot.handler;
                                n_oupd      = 1'b0;
                                n_olcnt     = '0;
                                n_olast     = 1'b0;
                            end
                        end
                        CMD_REG: begin
                            if (!r_found && !occ) begin
                                ram_we          = 1'b1;
                                wr_slot.handler = r_hid;
                                wr_slot.period  = period;
                                wr_slot.due     = r_tick + TICK_W'(period);
                                n_used[r_pidx]  = 1'b1;
                                n_found         = 1'b1;
                                n_sel           = 3'(r_pidx);
                                n_fail          = STAT_OK;
                            end
                        end
                        default: begin
                            // unregister; handler 0 matches free slots
                            if (occ ? (rd_slot.handler == r_hid) : (r_hid == '0)) begin
                                n_used[r_pidx] = 1'b0;
                                n_fail         = STAT_OK;
                            end
                        end
                    endcase
                end
            end

            S_DONE: begin
                n_valid = 1'b1;
                n_kind  = KIND_DONE;
                n_stat  = r_fail;
                n_oslot = r_sel;
                n_ohid  = '0;
                n_oupd  = r_upd;
                n_olcnt = r_upd ? r_legacy : '0;
                n_olast = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_used   <= '0;
            r_tick   <= '0;
            r_phase  <= '0;
            r_legacy <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_used   <= n_used;
            r_tick   <= n_tick;
            r_phase  <= n_phase;
            r_legacy <= n_legacy;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_cmd    <= n_cmd;
        r_hid    <= n_hid;
        r_ms_rnd <= n_ms_rnd;
        r_fail   <= n_fail;
        r_found  <= n_found;
        r_sel    <= n_sel;
        r_upd    <= n_upd;
        r_kind   <= n_kind;
        r_stat   <= n_stat;
        r_oslot  <= n_oslot;
        r_ohid   <= n_ohid;
        r_oupd   <= n_oupd;
        r_olcnt  <= n_olcnt;
        r_olast  <= n_olast;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_result_kind   = r_kind;
    assign o_status        = r_stat;
    assign o_slot_index    = r_oslot;
    assign o_fired_handler = r_ohid;
    assign o_tick_value    = r_tick;
    assign o_legacy_update = r_oupd;
    assign o_legacy_count  = r_olcnt;
    assign o_last          = r_olast;

endmodule
`default_nettype wire

>>> verif/periodic_event_slot_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_event_slot_table_test: self-checking bench for the slot table
// Drives tick, register, unregister and illegal commands through the
// start/busy port, tracks slot occupancy, due ticks and the /5 counter in a
// local model and checks every result strobe against it in order.
// ----------------------------------------------------------------------------
module periodic_event_slot_table_test;
    import pest_pkg::*;

    localparam int NSLOT        = SLOT_COUNT_DEF;
    localparam int STALL_LIMIT  = 2000;   // quiet cycles before giving up
    localparam int SETTLE_CYC   = 20;     // longer than a full table walk
    localparam int RAND_PER_PH  = 25;     // three phases, 75 random commands

    localparam logic [1:0] CMD_ILLEGAL = 2'd3;

    // one result transaction as seen on the o_* ports
    typedef struct {
        logic                kind;
        logic                status;
        logic [2:0]          slot;
        logic [HID_W-1:0]    hid;
        logic [TICK_W-1:0]   tick;
        logic                upd;
        logic [LEGACY_W-1:0] lcount;
        logic                last;
    } t_slot_event;

    // Tracks the slot table and holds the result transactions still owed.
    class slot_table_tracker;
        logic [TICK_W-1:0]   tick_ctr;
        logic [2:0]          phase5;
        logic [LEGACY_W-1:0] legacy;
        logic [HID_W-1:0]    slot_hid [NSLOT];
        logic [PERIOD_W-1:0] slot_per [NSLOT];
        logic [TICK_W-1:0]   slot_due [NSLOT];
        t_slot_event         owed_events [$];
        int                  fault_count;

        function new();
            tick_ctr    = '0;
            phase5      = '0;
            legacy      = '0;
            fault_count = 0;
            foreach (slot_hid[i]) begin
                slot_hid[i] = '0;
                slot_per[i] = '0;
                slot_due[i] = '0;
            end
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        // accepted command transaction: update the table, queue its results
        function void note_command(logic [1:0] cmd, logic [MS_W-1:0] ms,
                                   logic [HID_W-1:0] hid);
            t_slot_event       ev;
            t_slot_event       fire;
            logic [31:0]       ticks_per;
            logic              placed;
            logic              matched;
            logic              upd;
            ev = '{kind: KIND_DONE, status: STAT_FAIL, slot: '0, hid: '0,
                   tick: '0, upd: 1'b0, lcount: '0, last: 1'b1};
            case (cmd)
                CMD_TICK: begin
                    tick_ctr = tick_ctr + 32'd1;
                    upd = 1'b0;
                    // counter wrap restarts the /5 bookkeeping
                    if (tick_ctr == '0) begin
                        phase5 = '0;
                        legacy = '0;
                        upd    = 1'b1;
                    end else begin
                        phase5 = phase5 + 3'd1;
                        if (phase5 >= LEGACY_DIV) begin
                            phase5 = '0;
                            legacy = legacy + 30'd1;
                            upd    = 1'b1;
                        end
                    end
                    for (int i = 0; i < NSLOT; i++) begin
                        if (slot_hid[i] != '0 && tick_ctr >= slot_due[i]) begin
                            slot_due[i] = tick_ctr + TICK_W'(slot_per[i]);
                            fire = '{kind: KIND_FIRE, status: STAT_OK, slot: 3'(i),
                                     hid: slot_hid[i], tick: tick_ctr,
                                     upd: 1'b0, lcount: '0, last: 1'b0};
                            owed_events.push_back(fire);
                        end
                    end
                    ev.status = STAT_OK;
                    ev.upd    = upd;
                    ev.lcount = upd ? legacy : '0;
                end
                CMD_REG: begin
                    if (hid != '0 && ms != '0) begin
                        ticks_per = (32'(ms) + TICK_ROUND) / TICK_MS;
                        placed = 1'b0;
                        for (int i = 0; i < NSLOT; i++) begin
                            if (!placed && slot_hid[i] == '0) begin
                                slot_hid[i] = hid;
                                slot_per[i] = PERIOD_W'(ticks_per);
                                slot_due[i] = tick_ctr + ticks_per;
                                ev.status   = STAT_OK;
                                ev.slot     = 3'(i);
                                placed      = 1'b1;
                            end
                        end
                    end
                end
                CMD_UNREG: begin
                    // handler 0 matches free slots, so it succeeds if any is free
                    matched = 1'b0;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (slot_hid[i] == hid) begin
                            slot_hid[i] = '0;
                            slot_per[i] = '0;
                            slot_due[i] = '0;
                            matched     = 1'b1;
                        end
                    end
                    ev.status = matched ? STAT_OK : STAT_FAIL;
                end
                default: ;  // illegal command: failure completion only
            endcase
            ev.tick = tick_ctr;
            owed_events.push_back(ev);
        endfunction

        function void compare_field(string field, logic [31:0] want,
                                    logic [31:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0d actual %0d",
                         $time, field, want, got);
                fault_count++;
            end
        endfunction

        // result transaction off the port: must match the oldest owed one
        function void check_event(t_slot_event got);
            t_slot_event want;
            if (owed_events.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d",
                         $time, got.kind, " status %0d slot %0d handler %0d tick %0d",
                         got.status, got.slot, got.hid, got.tick);
                fault_count++;
                return;
            end
            want = owed_events.pop_front();
            compare_field("result_kind",   want.kind,   got.kind);
            compare_field("status",        want.status, got.status);
            compare_field("slot_index",    want.slot,   got.slot);
            compare_field("fired_handler", want.hid,    got.hid);
            compare_field("tick_value",    want.tick,   got.tick);
            compare_field("legacy_update", want.upd,    got.upd);
            compare_field("legacy_count",  want.lcount, got.lcount);
            compare_field("last",          want.last,   got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic [1:0]          i_cmd        = CMD_TICK;
    logic [MS_W-1:0]     i_period_ms  = '0;
    logic [HID_W-1:0]    i_handler_id = '0;
    logic                o_valid;
    logic                o_result_kind;
    logic                o_status;
    logic [2:0]          o_slot_index;
    logic [HID_W-1:0]    o_fired_handler;
    logic [TICK_W-1:0]   o_tick_value;
    logic                o_legacy_update;
    logic [LEGACY_W-1:0] o_legacy_count;
    logic                o_last;

    periodic_event_slot_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_period_ms     (i_period_ms),
        .i_handler_id    (i_handler_id),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_fired_handler (o_fired_handler),
        .o_tick_value    (o_tick_value),
        .o_legacy_update (o_legacy_update),
        .o_legacy_count  (o_legacy_count),
        .o_last          (o_last)
    );

    slot_table_tracker tracker = new();
    int                idle_pct = 0;     // sender gap probability, percent
    int                quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Sampled in the active region of the edge, so every value read
    // here is the pre-edge value the DUT itself saw. Results are checked
    // before the new command is noted; order is irrelevant anyway since a
    // command cannot produce a result on its own accept edge.
    // Also the watchdog: any edge with neither a command nor a result
    // transaction counts as quiet.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                tracker.check_event('{kind: o_result_kind, status: o_status,
                                      slot: o_slot_index, hid: o_fired_handler,
                                      tick: o_tick_value, upd: o_legacy_update,
                                      lcount: o_legacy_count, last: o_last});
            end
            if (start && !busy) begin
                tracker.note_command(i_cmd, i_period_ms, i_handler_id);
            end
            if (o_valid || (start && !busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("periodic_event_slot_table regression: fail");
                    $finish;
                end
            end
        end
    end

    // Present one command and return on the edge that accepts it. start is
    // left high so back-to-back commands never drop it for a step; random
    // gaps lower it, each in its own time step.
    task automatic issue(input logic [1:0] cmd, input logic [MS_W-1:0] ms,
                         input logic [HID_W-1:0] hid);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_period_ms  <= ms;
        i_handler_id <= hid;
        do @(posedge i_clk); while (busy);
    endtask

    // Sender backs off until every owed result has come out. The first edge
    // lets the monitor note the transaction accepted on this one.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: ticks to age the table, registrations from
    // a small handler pool with short periods so slots actually fire, and
    // unregisters from the same pool; a few wide-range and illegal commands.
    task automatic random_command();
        int               pick;
        int               msel;
        logic [MS_W-1:0]  ms;
        logic [HID_W-1:0] hid;
        pick = $urandom_range(0, 99);
        msel = $urandom_range(0, 99);
        hid  = ($urandom_range(0, 9) < 8) ? HID_W'($urandom_range(1, 6))
                                          : HID_W'($urandom_range(0, 255));
        if (msel < 70)
            ms = MS_W'($urandom_range(1, 60));
        else if (msel < 90)
            ms = MS_W'($urandom_range(0, 24'hFF_FFFF));
        else
            ms = (msel < 95) ? '0 : '1;
        if (pick < 50)
            issue(CMD_TICK, MS_W'($urandom), HID_W'($urandom));
        else if (pick < 75)
            issue(CMD_REG, ms, hid);
        else if (pick < 93)
            issue(CMD_UNREG, MS_W'($urandom), hid);
        else
            issue(CMD_ILLEGAL, MS_W'($urandom), HID_W'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: argument errors, empty-table corner cases, illegal cmd
        issue(CMD_TICK,  '0,        '0);
        issue(CMD_REG,   24'd100,   8'd0);      // handler 0 rejected
        issue(CMD_REG,   24'd0,     8'd5);      // period 0 rejected
        issue(CMD_UNREG, '0,        8'd7);      // nothing to remove
        issue(CMD_UNREG, '0,        8'd0);      // handler 0 hits free slots
        issue(CMD_ILLEGAL, '1,      '1);        // illegal command
        // fill all eight slots; rounding at 1, 10, 11 ms and max period
        issue(CMD_REG,   24'd1,     8'd1);
        issue(CMD_REG,   24'd10,    8'd2);
        issue(CMD_REG,   24'd11,    8'd3);
        issue(CMD_REG,   '1,        8'd255);
        issue(CMD_REG,   24'd25,    8'd1);      // same handler twice
        issue(CMD_REG,   24'd40,    8'd128);
        issue(CMD_REG,   24'd20,    8'd64);
        issue(CMD_REG,   24'd30,    8'd4);
        issue(CMD_REG,   24'd5,     8'd9);      // table full
        issue(CMD_UNREG, '0,        8'd0);      // no free slot: fails
        // ticks past the first /5 report, with several fires per tick
        repeat (5) issue(CMD_TICK, '0, '0);
        issue(CMD_UNREG, '0,        8'd1);      // removes two slots
        issue(CMD_TICK,  '0,        '0);
        issue(CMD_REG,   24'hAA_AAAA, 8'd170);
        issue(CMD_UNREG, '0,        8'd255);

        // random: sender gaps light, then heavy, then none
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 11 : (ph == 1) ? 85 : 0;
            for (int n = 0; n < RAND_PER_PH; n++) begin
                if (n == RAND_PER_PH / 2)
                    wait_for_drain();
                random_command();
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (tracker.fault_count == 0)
            $display("periodic_event_slot_table regression: pass");
        else
            $display("periodic_event_slot_table regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/pest_pkg.sv
hdl/pest_ram.sv
hdl/pest_div10.sv
hdl/periodic_event_slot_table.sv
verif/periodic_event_slot_table_test.sv
